// ===== rtl/lrcf_pkg.sv =====
// Shared types, codes and constants of the LED ring clock frame generator.
`timescale 1ns / 1ps

package lrcf_pkg;

  // Default strip geometry.
  localparam int DEF_NUM_LEDS = 60;
  localparam int DEF_HOUR_GAP = 5;

  // Field widths.
  localparam int FUNC_W    = 2;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int LED_IDX_W = 6;
  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 2;

  // Hour LED position: up to 23 hours times the default gap of 5.
  localparam int HOUR_LED_W = 7;

  // Time limits.
  localparam logic [SEC_W-1:0]  SEC_MAX       = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MIN_MAX       = MIN_W'(59);
  localparam logic [HOUR_W-1:0] HOUR_SET_MAX  = HOUR_W'(23);
  localparam logic [HOUR_W:0]   HOUR_DAY      = (HOUR_W+1)'(24);
  localparam logic [HOUR_W:0]   HOUR_HALF_DAY = (HOUR_W+1)'(12);

  // Operation codes of an input transaction.
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REDRAW = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HOUR_COLOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OTHER_COLOR  = 2'd2;

  // Register reset values.
  localparam logic [COLOR_W-1:0] HOUR_COLOR_RST   = 24'h320000;
  localparam logic [COLOR_W-1:0] MINUTE_COLOR_RST = 24'h003200;
  localparam logic [COLOR_W-1:0] OTHER_COLOR_RST  = 24'h000032;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One frame job handed from the front to the back.
  typedef struct packed {
    logic                  reject;
    logic [HOUR_LED_W-1:0] hour_led;
    logic [MIN_W-1:0]      minute;
  } job_t;

  // The three programmed colors.
  typedef struct packed {
    logic [COLOR_W-1:0] hour;
    logic [COLOR_W-1:0] minute;
    logic [COLOR_W-1:0] other;
  } color_set_t;

endpackage

// ===== rtl/lrcf_in_if.sv =====
// Channel interfaces: input, result and configuration write channels.
`timescale 1ns / 1ps

interface lrcf_in_if;
  import lrcf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [HOUR_W-1:0]     set_hour;
  logic [MIN_W-1:0]      set_minute;
  logic [SEC_W-1:0]      set_second;
  modport source (output valid, func, set_hour, set_minute, set_second, input ready);
  modport sink   (input valid, func, set_hour, set_minute, set_second, output ready);
endinterface

interface lrcf_out_if;
  import lrcf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 status;
  logic [LED_IDX_W-1:0] led_index;
  logic [CHAN_W-1:0]    red;
  logic [CHAN_W-1:0]    green;
  logic [CHAN_W-1:0]    blue;
  logic                 last;
  modport source (output valid, status, led_index, red, green, blue, last, input ready);
  modport sink   (input valid, status, led_index, red, green, blue, last, output ready);
endinterface

interface lrcf_cfg_if;
  import lrcf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lrcf_front.sv =====
// Front part: accepts input transactions, keeps the time and queues frame jobs.
`timescale 1ns / 1ps

module lrcf_front import lrcf_pkg::*; #(
  parameter int HOUR_GAP = DEF_HOUR_GAP
) (
  input  logic       clk,
  input  logic       rst_n,
  lrcf_in_if.sink    in_chan,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic [MIN_W-1:0]  minute_r, minute_nxt;
  logic [SEC_W-1:0]  second_r, second_nxt;
  logic [HOUR_W:0]   hour_inc;
  logic              set_bad;
  logic              accept;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  assign set_bad = (in_chan.set_hour > HOUR_SET_MAX) || (in_chan.set_minute > MIN_MAX) ||
                   (in_chan.set_second > SEC_MAX);

  always_comb begin
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    hour_inc   = {1'b0, hour_r} + 1'b1;
    case (in_chan.func)
      FUNC_TICK: begin
        if (second_r == SEC_MAX) begin
          second_nxt = '0;
          if (minute_r == MIN_MAX) begin
            minute_nxt = '0;
            // An hour loaded past twelve folds back into the twelve-hour range.
            if (hour_inc >= HOUR_DAY) begin
              hour_nxt = '0;
            end else if (hour_inc >= HOUR_HALF_DAY) begin
              hour_nxt = HOUR_W'(hour_inc - HOUR_HALF_DAY);
            end else begin
              hour_nxt = HOUR_W'(hour_inc);
            end
          end else begin
            minute_nxt = minute_r + 1'b1;
          end
        end else begin
          second_nxt = second_r + 1'b1;
        end
      end
      FUNC_SET: begin
        if (!set_bad) begin
          hour_nxt   = in_chan.set_hour;
          minute_nxt = in_chan.set_minute;
          second_nxt = in_chan.set_second;
        end
      end
      default: begin
      end
    endcase
  end

  assign q_push          = accept;
  assign q_job.reject    = (in_chan.func == FUNC_SET) && set_bad;
  assign q_job.hour_led  = HOUR_LED_W'(hour_nxt * HOUR_GAP);
  assign q_job.minute    = minute_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
    end else if (accept) begin
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== rtl/lrcf_queue.sv =====
// Short job queue between the front and the back.
`timescale 1ns / 1ps

module lrcf_queue import lrcf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/lrcf_back.sv =====
// Back part: walks the strip for each queued job and drives the result register.
`timescale 1ns / 1ps

module lrcf_back import lrcf_pkg::*; #(
  parameter int NUM_LEDS = DEF_NUM_LEDS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  color_set_t colors,
  input  job_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  lrcf_out_if.source out_chan
);

  localparam int LED_W = $clog2(NUM_LEDS);

  job_t               job_r;
  logic               busy_r;
  logic [LED_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic               status_r, last_r;
  logic [LED_IDX_W-1:0] index_r;
  logic [COLOR_W-1:0] color_r;
  logic [COLOR_W-1:0] pix_color;
  logic               advance, emit, last_pix;

  assign advance  = !out_valid_r || out_chan.ready;
  assign emit     = busy_r && advance;
  assign last_pix = job_r.reject || (cnt_r == LED_W'(NUM_LEDS - 1));
  assign q_pop    = !q_empty && (!busy_r || (emit && last_pix));

  always_comb begin
    if (HOUR_LED_W'(cnt_r) == job_r.hour_led) begin
      pix_color = colors.hour;
    end else if (LED_IDX_W'(cnt_r) <= job_r.minute) begin
      pix_color = colors.minute;
    end else begin
      pix_color = colors.other;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (emit && last_pix) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (advance) begin
        out_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= head;
    end
    if (emit) begin
      status_r <= job_r.reject;
      last_r   <= last_pix;
      index_r  <= job_r.reject ? '0 : LED_IDX_W'(cnt_r);
      color_r  <= job_r.reject ? '0 : pix_color;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = status_r;
  assign out_chan.last      = last_r;
  assign out_chan.led_index = index_r;
  assign out_chan.red       = color_r[23:16];
  assign out_chan.green     = color_r[15:8];
  assign out_chan.blue      = color_r[7:0];

endmodule

// ===== rtl/led_ring_clock_frame.sv =====
// Top level of the LED ring clock frame generator.
`timescale 1ns / 1ps

// The block keeps a twelve-hour time of day and, for every accepted input
// transaction (tick, set or redraw), sends one frame of NUM_LEDS pixel
// transactions in strip order, the final one marked last. The hour LED sits at
// hour*HOUR_GAP and shows the hour color; LEDs up to the minute count show the
// minute color; all others show the other color. A set with an out-of-range
// field changes nothing and sends one status transaction instead of a frame.
// A frame has NUM_LEDS pixels (60 by default). The single pixel counter in the
// back part emits one pixel per cycle while the output is not stalled, and the
// back takes the next queued job as it emits the last pixel of a frame. The
// front accepts a new input while the back still draws, until the two-entry job
// queue is full. With the back idle, an accepted input goes from the job queue
// into the back part's job register and then into the result register. Colors
// must only be written while no frame is pending.

module led_ring_clock_frame import lrcf_pkg::*; #(
  parameter int NUM_LEDS = DEF_NUM_LEDS,
  parameter int HOUR_GAP = DEF_HOUR_GAP
) (
  input  logic        clk,
  input  logic        rst_n,
  lrcf_in_if.sink     in_chan,
  lrcf_out_if.source  out_chan,
  lrcf_cfg_if.sink    cfg_chan
);

  color_set_t colors_r;
  job_t       q_in_job, q_head;
  logic       q_push, q_pop, q_empty, q_full;

  // Color registers are always writable; an index beyond the list is dropped.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colors_r.hour   <= HOUR_COLOR_RST;
      colors_r.minute <= MINUTE_COLOR_RST;
      colors_r.other  <= OTHER_COLOR_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        CFG_HOUR_COLOR:   colors_r.hour   <= cfg_chan.data;
        CFG_MINUTE_COLOR: colors_r.minute <= cfg_chan.data;
        CFG_OTHER_COLOR:  colors_r.other  <= cfg_chan.data;
        default: begin
        end
      endcase
    end
  end

  // The front updates the time and turns each transaction into a frame job.
  lrcf_front #(
    .HOUR_GAP (HOUR_GAP)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_in_job)
  );

  // The queue lets the front run ahead of the frame being drawn.
  lrcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back draws each job one pixel per cycle into the result register while the output is not stalled.
  lrcf_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .colors   (colors_r),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
